// File: rtl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// shared types and constants of the source tokenizer
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int unsigned CHAR_W  = 21;
    localparam int unsigned TYPE_W  = 6;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned NKW     = 12;

    // scan modes, one-hot
    typedef enum logic [8:0] {
        M_IDLE      = 9'b000000001,
        M_IDENT     = 9'b000000010,
        M_NUMBER    = 9'b000000100,
        M_OPER      = 9'b000001000,
        M_CHAR_OPEN = 9'b000010000,
        M_CHAR_BODY = 9'b000100000,
        M_STRING    = 9'b001000000,
        M_COMMENT   = 9'b010000000,
        M_HALT      = 9'b100000000
    } t_mode;

    // input item: one source character
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
    } t_src;

    localparam logic [TYPE_W-1:0] T_PRINT = 6'd0;
    localparam logic [TYPE_W-1:0] T_ID    = 6'd3;
    localparam logic [TYPE_W-1:0] T_INT   = 6'd4;
    localparam logic [TYPE_W-1:0] T_FLOAT = 6'd5;
    localparam logic [TYPE_W-1:0] T_CHAR  = 6'd7;
    localparam logic [TYPE_W-1:0] T_STR   = 6'd8;
    localparam logic [TYPE_W-1:0] T_EOF   = 6'd36;

    localparam logic [ERR_W-1:0] E_NONE   = 3'd0;
    localparam logic [ERR_W-1:0] E_OPER   = 3'd1;
    localparam logic [ERR_W-1:0] E_NUMBER = 3'd2;
    localparam logic [ERR_W-1:0] E_CHAR   = 3'd3;
    localparam logic [ERR_W-1:0] E_STRING = 3'd4;
    localparam logic [ERR_W-1:0] E_SYMBOL = 3'd5;

    // token request from front to back: kind, which offset, which length
    typedef struct packed {
        logic [TYPE_W-1:0] ttype;
        logic [ERR_W-1:0]  err;
        logic              use_begin; // column from token start, else char offset
        logic              len_one;   // length is one, else zero or body
        logic              len_body;
    } t_tok;

    function automatic logic [3:0] op_code(input logic [CHAR_W-1:0] c);
        logic [3:0] r;
        r = 4'd0;
        unique case (c)
            21'h3D: r = 4'd1;
            21'h2B: r = 4'd2;
            21'h2D: r = 4'd3;
            21'h2A: r = 4'd4;
            21'h2F: r = 4'd5;
            21'h25: r = 4'd6;
            21'h3C: r = 4'd7;
            21'h3E: r = 4'd8;
            21'h21: r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [TYPE_W-1:0] symbol_type(input logic [CHAR_W-1:0] c);
        logic [TYPE_W-1:0] r;
        r = 6'd0;
        unique case (c)
            21'h28:  r = 6'd28;
            21'h29:  r = 6'd29;
            21'h7B:  r = 6'd30;
            21'h7D:  r = 6'd31;
            21'h5B:  r = 6'd32;
            21'h5D:  r = 6'd33;
            21'h3A:  r = 6'd34;
            21'h61B: r = 6'd35;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] t [NKW];
        t = '{4'd4, 4'd8, 4'd2, 4'd3, 4'd2, 4'd1, 4'd3, 4'd2, 4'd3, 4'd3, 4'd5, 4'd2};
        return t[k];
    endfunction

    function automatic logic [TYPE_W-1:0] kw_type(input int k);
        logic [TYPE_W-1:0] t [NKW];
        t = '{6'd0, 6'd1, 6'd6, 6'd6, 6'd16, 6'd15, 6'd17, 6'd2, 6'd24, 6'd25,
              6'd26, 6'd27};
        return t[k];
    endfunction

    // keyword character at position p (0..7), zero past the end
    function automatic logic [10:0] kw_char(input int k, input logic [2:0] p);
        logic [10:0] t [NKW][8];
        t = '{
            '{11'h627, 11'h637, 11'h628, 11'h639, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h627, 11'h642, 11'h631, 11'h623, 11'h05F, 11'h633, 11'h637, 11'h631},
            '{11'h635, 11'h62D, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h62E, 11'h637, 11'h623, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h623, 11'h648, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h648, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h644, 11'h64A, 11'h633, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h62F, 11'h639, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h625, 11'h630, 11'h627, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h644, 11'h643, 11'h644, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0},
            '{11'h637, 11'h627, 11'h644, 11'h645, 11'h627, 11'h0, 11'h0, 11'h0},
            '{11'h641, 11'h64A, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0, 11'h0}
        };
        return t[k][p];
    endfunction

endpackage

// File: rtl/ast_stream_if.sv
// ----------------------------------------------------------------------------
// ast_stream_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface ast_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ast_front.sv
// ----------------------------------------------------------------------------
// ast_front
// per-character scanner: updates the lexer state, emits up to two results
// ----------------------------------------------------------------------------
module ast_front #(
    parameter int unsigned LENGTH_WIDTH = 16,
    parameter int unsigned OFFSET_WIDTH = 24,
    parameter int unsigned LINE_WIDTH   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [ast_pkg::CHAR_W-1:0]   i_char,
    output logic [1:0]                   o_count,
    output ast_pkg::t_tok                o_tok0,
    output ast_pkg::t_tok                o_tok1,
    output logic [LENGTH_WIDTH-1:0]      o_body,
    output logic [OFFSET_WIDTH-1:0]      o_begin,
    output logic [OFFSET_WIDTH-1:0]      o_off,
    output logic [LINE_WIDTH-1:0]        o_line0,
    output logic [LINE_WIDTH-1:0]        o_line1
);
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
    localparam logic [LINE_WIDTH-1:0]   LIN_MAX = '1;

    ast_pkg::t_mode              r_mode, n_mode;
    logic [LENGTH_WIDTH-1:0]     r_len, n_len;
    logic [ast_pkg::NKW-1:0]     r_kw, n_kw;
    logic [8:0]                  r_ops, n_ops;
    logic                        r_per, n_per;
    logic [LINE_WIDTH-1:0]       r_line, n_line;
    logic [OFFSET_WIDTH-1:0]     r_off, n_off;
    logic [OFFSET_WIDTH-1:0]     r_beg, n_beg;

    logic [ast_pkg::CHAR_W-1:0] c;
    logic is_start, is_dig, is_blank, redo;
    logic [3:0] opc;
    logic [ast_pkg::TYPE_W-1:0] sym, id_t, op_t;
    logic [LENGTH_WIDTH-1:0] l_inc;
    logic [ast_pkg::NKW-1:0] kw_next;
    logic [1:0] n;
    ast_pkg::t_tok t0, t1;
    logic [ast_pkg::NKW-1:0] kw_first;

    function automatic ast_pkg::t_tok mk(input logic [ast_pkg::TYPE_W-1:0] ty,
                                         input logic [ast_pkg::ERR_W-1:0] er,
                                         input logic ub, input logic l1,
                                         input logic lb);
        ast_pkg::t_tok t;
        t.ttype = ty; t.err = er; t.use_begin = ub; t.len_one = l1; t.len_body = lb;
        return t;
    endfunction

    assign c        = i_char;
    assign is_start = (c >= 21'h600 && c <= 21'h6FF && c != 21'h61B) || c == 21'h5F;
    assign is_dig   = c >= 21'h30 && c <= 21'h39;
    assign is_blank = c == 21'h20 || c == 21'h09 || c == 21'h0D || c == 21'h0B
                      || c == 21'h0C;
    assign opc      = ast_pkg::op_code(c);
    assign sym      = ast_pkg::symbol_type(c);
    assign l_inc    = (r_len == LEN_MAX) ? r_len : r_len + 1'b1;

    // identifier keyword resolution from current state
    always_comb begin
        id_t = ast_pkg::T_ID;
        for (int k = ast_pkg::NKW - 1; k >= 0; k--) begin
            if (r_kw[k] && r_len == LENGTH_WIDTH'(ast_pkg::kw_len(k)))
                id_t = ast_pkg::kw_type(k);
        end
    end

    // operator run resolution
    always_comb begin
        logic [3:0] a, b;
        a = r_ops[3:0];
        b = r_ops[7:4];
        op_t = 6'd0;
        if (!r_ops[8]) begin
            if (r_len == LENGTH_WIDTH'(1)) begin
                unique case (a)
                    4'd1: op_t = 6'd9;
                    4'd2: op_t = 6'd10;
                    4'd3: op_t = 6'd11;
                    4'd4: op_t = 6'd12;
                    4'd5: op_t = 6'd13;
                    4'd6: op_t = 6'd14;
                    4'd7: op_t = 6'd20;
                    4'd8: op_t = 6'd22;
                    default: op_t = 6'd0;
                endcase
            end else if (r_len == LENGTH_WIDTH'(2) && b == 4'd1) begin
                unique case (a)
                    4'd1: op_t = 6'd18;
                    4'd9: op_t = 6'd19;
                    4'd7: op_t = 6'd21;
                    4'd8: op_t = 6'd23;
                    default: op_t = 6'd0;
                endcase
            end
        end
    end

    // keyword narrowing: continuing the current name, and starting a fresh one
    always_comb begin
        kw_next  = r_kw;
        kw_first = '1;
        for (int k = 0; k < ast_pkg::NKW; k++) begin
            if (r_len >= LENGTH_WIDTH'(ast_pkg::kw_len(k)) ||
                ast_pkg::kw_char(k, r_len[2:0]) != c[10:0] || c[20:11] != '0)
                kw_next[k] = 1'b0;
            if (ast_pkg::kw_char(k, 3'd0) != c[10:0] || c[20:11] != '0)
                kw_first[k] = 1'b0;
        end
    end

    always_comb begin
        n_mode = r_mode; n_len = r_len; n_kw = r_kw; n_ops = r_ops; n_per = r_per;
        n_line = r_line; n_off = r_off; n_beg = r_beg;
        redo = 1'b0; n = 2'd0;
        t0 = mk(6'd0, ast_pkg::E_NONE, 1'b0, 1'b0, 1'b0);
        t1 = t0;

        unique case (r_mode)
            ast_pkg::M_IDENT: begin
                if (is_start || is_dig) begin
                    n_kw = kw_next; n_len = l_inc;
                end else begin
                    t0 = mk(id_t, ast_pkg::E_NONE, 1'b1, 1'b0, 1'b1); n = 2'd1;
                    redo = 1'b1;
                end
            end
            ast_pkg::M_NUMBER: begin
                if (is_dig) n_len = l_inc;
                else if (c == 21'h2E) begin
                    if (r_per) begin
                        t0 = mk(ast_pkg::T_FLOAT, ast_pkg::E_NUMBER, 1'b0, 1'b0, 1'b1);
                        n = 2'd1; n_mode = ast_pkg::M_HALT;
                    end else begin
                        n_per = 1'b1; n_len = l_inc;
                    end
                end else begin
                    t0 = mk(r_per ? ast_pkg::T_FLOAT : ast_pkg::T_INT, ast_pkg::E_NONE,
                            1'b1, 1'b0, 1'b1);
                    n = 2'd1; redo = 1'b1;
                end
            end
            ast_pkg::M_OPER: begin
                if (opc != 4'd0) begin
                    if (r_len == '0) n_ops = r_ops | {5'd0, opc};
                    else if (r_len == LENGTH_WIDTH'(1)) n_ops = r_ops | {1'b0, opc, 4'd0};
                    else n_ops = r_ops | 9'h100;
                    n_len = l_inc;
                end else begin
                    t0 = mk(op_t, (op_t == 6'd0) ? ast_pkg::E_OPER : ast_pkg::E_NONE,
                            1'b1, 1'b0, 1'b1);
                    n = 2'd1; redo = 1'b1;
                end
            end
            ast_pkg::M_CHAR_OPEN, ast_pkg::M_CHAR_BODY: begin
                if (c == 21'h2019) begin
                    t0 = mk(ast_pkg::T_CHAR, ast_pkg::E_NONE, 1'b1, 1'b0, 1'b1);
                    n = 2'd1; n_mode = ast_pkg::M_IDLE;
                end else if (r_mode == ast_pkg::M_CHAR_OPEN && c != '0) begin
                    n_len = LENGTH_WIDTH'(1); n_mode = ast_pkg::M_CHAR_BODY;
                end else begin
                    t0 = mk(ast_pkg::T_CHAR, ast_pkg::E_CHAR, 1'b0, 1'b0, 1'b1);
                    n = 2'd1; n_mode = ast_pkg::M_HALT; redo = (c == '0);
                end
            end
            ast_pkg::M_STRING: begin
                if (c == 21'h22) begin
                    t0 = mk(ast_pkg::T_STR, ast_pkg::E_NONE, 1'b1, 1'b0, 1'b1);
                    n = 2'd1; n_mode = ast_pkg::M_IDLE;
                end else if (c == '0) begin
                    t0 = mk(ast_pkg::T_STR, ast_pkg::E_STRING, 1'b0, 1'b0, 1'b1);
                    n = 2'd1; redo = 1'b1;
                end else n_len = l_inc;
            end
            ast_pkg::M_COMMENT: redo = (c == 21'h0A || c == '0);
            ast_pkg::M_HALT:    redo = (c == '0);
            default:            redo = 1'b1;
        endcase

        if (redo) begin
            ast_pkg::t_tok tr;
            logic emit;
            emit = 1'b0;
            tr = t0;
            n_mode = ast_pkg::M_IDLE; n_len = '0; n_kw = '1; n_ops = '0; n_per = 1'b0;
            n_beg = r_off;
            if (c == '0) begin
                tr = mk(ast_pkg::T_EOF, ast_pkg::E_NONE, 1'b0, 1'b0, 1'b0); emit = 1'b1;
            end else if (is_blank) begin
            end else if (c == 21'h0A) begin
                if (r_line != LIN_MAX) n_line = r_line + 1'b1;
            end else if (is_start) begin
                n_mode = ast_pkg::M_IDENT; n_kw = kw_first; n_len = LENGTH_WIDTH'(1);
            end else if (is_dig) begin
                n_mode = ast_pkg::M_NUMBER; n_len = LENGTH_WIDTH'(1);
            end else if (opc != 4'd0) begin
                n_mode = ast_pkg::M_OPER; n_ops = {5'd0, opc}; n_len = LENGTH_WIDTH'(1);
            end else if (sym != 6'd0) begin
                tr = mk(sym, ast_pkg::E_NONE, 1'b0, 1'b1, 1'b0); emit = 1'b1;
            end else if (c == 21'h2018) n_mode = ast_pkg::M_CHAR_OPEN;
            else if (c == 21'h22) n_mode = ast_pkg::M_STRING;
            else if (c == 21'h23) n_mode = ast_pkg::M_COMMENT;
            else begin
                tr = mk(ast_pkg::T_PRINT, ast_pkg::E_SYMBOL, 1'b0, 1'b0, 1'b0);
                emit = 1'b1; n_mode = ast_pkg::M_HALT;
            end
            if (emit) begin
                if (n == 2'd0) t0 = tr; else t1 = tr;
                n = n + 2'd1;
            end
        end

        if (redo && c == '0) begin
            n_line = LINE_WIDTH'(1); n_off = '0; n_beg = '0;
        end else if (r_off != OFF_MAX) n_off = r_off + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ast_pkg::M_IDLE; r_len <= '0; r_kw <= '1; r_ops <= '0;
            r_per <= 1'b0; r_line <= LINE_WIDTH'(1); r_off <= '0; r_beg <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode; r_len <= n_len; r_kw <= n_kw; r_ops <= n_ops;
            r_per <= n_per; r_line <= n_line; r_off <= n_off; r_beg <= n_beg;
        end
    end

    assign o_count = n;
    assign o_tok0  = t0;
    assign o_tok1  = t1;
    assign o_body  = r_len;
    assign o_begin = r_beg;
    assign o_off   = r_off;
    assign o_line0 = r_line;
    // second result sees the same line as the first (only eof resets it)
    assign o_line1 = r_line;
endmodule

// File: rtl/ast_back.sv
// ----------------------------------------------------------------------------
// ast_back
// result queue and formatter: stores result items and drives the output
// ----------------------------------------------------------------------------
module ast_back #(
    parameter int unsigned LENGTH_WIDTH = 16,
    parameter int unsigned OFFSET_WIDTH = 24,
    parameter int unsigned LINE_WIDTH   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [1:0]                   i_count,
    input  ast_pkg::t_tok                i_tok0,
    input  ast_pkg::t_tok                i_tok1,
    input  logic [LENGTH_WIDTH-1:0]      i_body,
    input  logic [OFFSET_WIDTH-1:0]      i_begin,
    input  logic [OFFSET_WIDTH-1:0]      i_off,
    input  logic [LINE_WIDTH-1:0]        i_line0,
    input  logic [LINE_WIDTH-1:0]        i_line1,
    input  logic                         i_pop,
    output logic                         o_space,
    output logic                         o_valid,
    output logic [ast_pkg::TYPE_W-1:0]   o_type,
    output logic [LENGTH_WIDTH-1:0]      o_len,
    output logic [LINE_WIDTH-1:0]        o_line,
    output logic [OFFSET_WIDTH-1:0]      o_col,
    output logic [ast_pkg::ERR_W-1:0]    o_err,
    output logic                         o_last
);
    localparam int unsigned DEPTH = 4;
    localparam int unsigned ENT_W = ast_pkg::TYPE_W + LENGTH_WIDTH + LINE_WIDTH
                                    + OFFSET_WIDTH + ast_pkg::ERR_W + 1;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic [ENT_W-1:0] e0, e1;
    logic do_pop;

    function automatic logic [ENT_W-1:0] fmt(input ast_pkg::t_tok t,
                                             input logic [LENGTH_WIDTH-1:0] body,
                                             input logic [OFFSET_WIDTH-1:0] beg,
                                             input logic [OFFSET_WIDTH-1:0] off,
                                             input logic [LINE_WIDTH-1:0] ln,
                                             input logic last);
        logic [OFFSET_WIDTH-1:0] o, col;
        logic [LENGTH_WIDTH-1:0] l;
        o = t.use_begin ? beg : off;
        col = (o == OFF_MAX) ? o : o + 1'b1;
        l = t.len_body ? body : (t.len_one ? LENGTH_WIDTH'(1) : '0);
        return {t.ttype, l, ln, col, t.err, last};
    endfunction

    assign e0 = fmt(i_tok0, i_body, i_begin, i_off, i_line0, i_count == 2'd1);
    assign e1 = fmt(i_tok1, i_body, i_begin, i_off, i_line1, 1'b1);
    assign do_pop = i_pop && r_cnt != '0;
    assign o_space = r_cnt <= 3'(DEPTH - 2);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push) n_cnt = n_cnt + 3'(i_count);
        if (do_pop) n_cnt = n_cnt - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_count != 2'd0) r_mem[r_wp] <= e0;
        if (i_push && i_count == 2'd2) r_mem[r_wp + 2'd1] <= e1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + i_count;
            if (do_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = r_cnt != '0;
    assign {o_type, o_len, o_line, o_col, o_err, o_last} = r_mem[r_rp];
endmodule

// File: rtl/arabic_source_tokenizer.sv
// ----------------------------------------------------------------------------
// arabic_source_tokenizer
// streaming lexer for an arabic-keyword source language
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  i_src     in    char_code (0 ends the source)
//  o_tok     out   token_type, token_length, line, column, error_code, last
//
//  one character item per cycle while the queue has room; each yields zero, one or two result items
//  the scanner updates its state in the accepting cycle; results enter a
//  four-entry queue whose head drives the output port
//  input is held off only while the queue lacks room for two more results
//  synchronous active-low reset returns the scanner to idle, line one
// ----------------------------------------------------------------------------
module arabic_source_tokenizer #(
    parameter int unsigned LENGTH_WIDTH = 16,
    parameter int unsigned OFFSET_WIDTH = 24,
    parameter int unsigned LINE_WIDTH   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ast_stream_if.sink   i_src,
    ast_stream_if.source o_tok
);
    ast_pkg::t_tok tok0, tok1;
    logic [1:0] count;
    logic [LENGTH_WIDTH-1:0] body;
    logic [OFFSET_WIDTH-1:0] beg, off;
    logic [LINE_WIDTH-1:0] line0, line1;
    logic space, fire;

    // accept while the queue can take the worst case of two results
    assign i_src.ready = space;
    assign fire = i_src.valid && space;

    ast_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH), .OFFSET_WIDTH(OFFSET_WIDTH), .LINE_WIDTH(LINE_WIDTH)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire),
        .i_char(i_src.data.char_code),
        .o_count(count), .o_tok0(tok0), .o_tok1(tok1), .o_body(body),
        .o_begin(beg), .o_off(off), .o_line0(line0), .o_line1(line1)
    );

    ast_back #(
        .LENGTH_WIDTH(LENGTH_WIDTH), .OFFSET_WIDTH(OFFSET_WIDTH), .LINE_WIDTH(LINE_WIDTH)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire), .i_count(count),
        .i_tok0(tok0), .i_tok1(tok1), .i_body(body), .i_begin(beg), .i_off(off),
        .i_line0(line0), .i_line1(line1), .i_pop(o_tok.ready), .o_space(space),
        .o_valid(o_tok.valid), .o_type(o_tok.data.token_type),
        .o_len(o_tok.data.token_length), .o_line(o_tok.data.line),
        .o_col(o_tok.data.column), .o_err(o_tok.data.error_code),
        .o_last(o_tok.data.last)
    );
endmodule
